@@ rtl/multiset_count_table_unit_defines.svh @@
// Assertion macros for the multiset count table.
`ifndef MULTISET_COUNT_TABLE_UNIT_DEFINES_SVH
`define MULTISET_COUNT_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MCT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define MCT_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define MCT_ASSERT(label, clk, rstn, prop, msg)
`define MCT_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif

`endif

@@ rtl/mct_pkg.sv @@
`default_nettype none
package mct_pkg;

    localparam int NUM_IDS_DEF    = 1024;
    localparam int COUNT_BITS_DEF = 32;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 10;
    localparam int AMT_W    = 32;
    localparam int SIZE_W   = 11;
    localparam int IDX_W    = 17;

    localparam logic [MODE_W-1:0] MODE_ADD         = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONSUME     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONSUME_ALL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CHECK       = 2'd3;

    localparam logic [SIZE_W-1:0] ALPHABET_RESET = 11'd1024;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              in_range;
        logic              id_zero;
        logic [AMT_W-1:0]  amount;
    } op_t;

endpackage
`default_nettype wire

@@ rtl/multiset_count_table_unit.sv @@
// Flow: an input beat is taken in idle together with its count memory read,
// then executes when the output is free, writing back the count and the result.
// A new beat is not taken until the last one has executed; a held result
// stalls the next item only in execute, after its read. Reset: synchronous
// active-low; afterwards a clearing pass writes every count entry, during which no input beat is taken.
`default_nettype none
`include "multiset_count_table_unit_defines.svh"
module multiset_count_table_unit
    import mct_pkg::*;
#(
    parameter int NUM_IDS    = NUM_IDS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // object_id[9:0], amount[41:10], zero pad
    input  wire logic [1:0]        s_tuser,   // mode[1:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata    // result_value[31:0], distinct_objects[42:32]
);

    localparam int ADDR_W = $clog2(NUM_IDS);
    localparam int ENT_W  = COUNT_BITS + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [SIZE_W-1:0] alpha_reg;
    logic [SIZE_W-1:0] total_reg, total_next;
    op_t               op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              m_valid_reg, m_valid_next;
    logic [AMT_W-1:0]  m_result_reg;
    logic [SIZE_W-1:0] m_total_reg;

    logic [ENT_W-1:0]  mem [NUM_IDS];
    logic [ENT_W-1:0]  rd_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [ENT_W-1:0]  mem_wd;

    logic [ID_W-1:0]   in_id;
    logic [IDX_W-1:0]  in_idx;
    logic              accept;
    logic              out_free;
    logic              exec_fire;
    op_t               op_in;

    logic                  upd_we;
    logic [COUNT_BITS-1:0] upd_count;
    logic                  upd_present;
    logic [AMT_W-1:0]      upd_result;
    logic [SIZE_W-1:0]     upd_total;

    assign in_id    = s_tdata[ID_W-1:0];
    assign in_idx   = IDX_W'(in_id);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    always_comb begin
        op_in.mode     = s_tuser;
        op_in.in_range = ({1'b0, in_id} < alpha_reg) && (in_idx < IDX_W'(NUM_IDS));
        op_in.id_zero  = (in_id == '0);
        op_in.amount   = s_tdata[ID_W +: AMT_W];
    end

    mct_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .op          (op_reg),
        .cur_count   (rd_reg[COUNT_BITS-1:0]),
        .cur_present (rd_reg[COUNT_BITS]),
        .total       (total_reg),
        .wr_en       (upd_we),
        .new_count   (upd_count),
        .new_present (upd_present),
        .result      (upd_result),
        .total_next  (upd_total)
    );

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        total_next    = total_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        mem_we        = 1'b0;
        mem_wa        = addr_reg;
        mem_wd        = {upd_present, upd_count};
        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                mem_wd        = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(NUM_IDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    mem_we       = upd_we;
                    total_next   = upd_total;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            alpha_reg    <= ALPHABET_RESET;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            total_reg    <= total_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                alpha_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= op_in;
            addr_reg <= in_idx[ADDR_W-1:0];
        end
        if (exec_fire) begin
            m_result_reg <= upd_result;
            m_total_reg  <= upd_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            rd_reg <= mem[in_idx[ADDR_W-1:0]];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_total_reg, m_result_reg};

    `MCT_ASSERT(a_no_take_while_clearing, aclk, aresetn,
        (state_reg == ST_CLEAR) |-> !s_tready, "input taken during clearing pass")
    `MCT_ASSERT(a_mem_write_source, aclk, aresetn,
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_EXEC),
        "count memory written outside clear or execute")
    `MCT_ASSERT_NEXT(a_total_only_on_exec, aclk, aresetn,
        state_reg != ST_EXEC, $stable(total_reg), "distinct total moved without an operation")
    `MCT_ASSERT(a_result_from_exec, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC), "result raised without execute")
    `MCT_ASSERT_NEXT(a_exec_returns_idle, aclk, aresetn,
        exec_fire, state_reg == ST_IDLE, "execute did not retire the item")

endmodule
`default_nettype wire

@@ rtl/mct_update.sv @@
`default_nettype none
module mct_update
    import mct_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire op_t                   op,
    input  wire logic [COUNT_BITS-1:0] cur_count,
    input  wire logic                  cur_present,
    input  wire logic [SIZE_W-1:0]     total,
    output logic                       wr_en,
    output logic [COUNT_BITS-1:0]      new_count,
    output logic                       new_present,
    output logic [AMT_W-1:0]           result,
    output logic [SIZE_W-1:0]          total_next
);

    localparam logic [AMT_W:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    logic [AMT_W-1:0] cnt_ext;
    logic [AMT_W:0]   sum;
    logic [AMT_W:0]   sum_sat;

    assign cnt_ext = AMT_W'(cur_count);
    assign sum     = {1'b0, cnt_ext} + {1'b0, op.amount};
    assign sum_sat = (sum > COUNT_MAX) ? COUNT_MAX : sum;

    always_comb begin
        wr_en       = 1'b0;
        new_count   = cur_count;
        new_present = cur_present;
        result      = '0;
        total_next  = total;
        if (op.in_range) begin
            if (op.id_zero) begin
                case (op.mode)
                    MODE_ADD, MODE_CONSUME: result = op.amount;
                    MODE_CONSUME_ALL:       result = AMT_W'(1);
                    default:                result = '0;
                endcase
            end else begin
                case (op.mode)
                    MODE_ADD: begin
                        wr_en       = 1'b1;
                        new_count   = sum_sat[COUNT_BITS-1:0];
                        new_present = 1'b1;
                        result      = sum_sat[AMT_W-1:0];
                        if (!cur_present) begin
                            total_next = total + SIZE_W'(1);
                        end
                    end
                    MODE_CONSUME: begin
                        if (cur_present && cnt_ext > op.amount) begin
                            wr_en     = 1'b1;
                            new_count = COUNT_BITS'(cnt_ext - op.amount);
                            result    = op.amount;
                        end else if (cur_present && cnt_ext == op.amount) begin
                            wr_en       = 1'b1;
                            new_count   = '0;
                            new_present = 1'b0;
                            result      = op.amount;
                            total_next  = total - SIZE_W'(1);
                        end
                    end
                    MODE_CONSUME_ALL: begin
                        if (cur_present) begin
                            wr_en       = 1'b1;
                            new_count   = '0;
                            new_present = 1'b0;
                            result      = cnt_ext;
                            total_next  = total - SIZE_W'(1);
                        end
                    end
                    default: begin
                        result = cur_present ? cnt_ext : '0;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire
